// File: rtl/gme_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 1x3 grayscale erosion/dilation block.
// No dependencies; every other file of the block depends on this package.
package gme_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int OFFSET_W   = 8;
    localparam int RESULT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    // Wide enough to hold any sum or difference of a pixel and an offset exactly
    localparam int SUM_W      = ((PIXEL_BITS > OFFSET_W) ? PIXEL_BITS : OFFSET_W) + 2;

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_DILATE   = 2'd0,
        CFG_OFFSET_LEFT   = 2'd1,
        CFG_OFFSET_CENTER = 2'd2,
        CFG_OFFSET_RIGHT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                mode_dilate;
        logic [OFFSET_W-1:0] offset_left;
        logic [OFFSET_W-1:0] offset_center;
        logic [OFFSET_W-1:0] offset_right;
    } cfg_t;

    // One queued window: left (already zeroed when outside the row), center,
    // right, whether the center result is due, and whether the row ends here.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] left;
        logic [PIXEL_BITS-1:0] center;
        logic [PIXEL_BITS-1:0] right;
        logic                  emit_center;
        logic                  last;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

// File: rtl/gme_pix_if.sv
`timescale 1ns / 1ps
// Input pixel channel: valid/ready handshake with pixel and row-end mark.
// Depends on gme_pkg.
interface gme_pix_if;
    logic                           valid;
    logic                           ready;
    logic [gme_pkg::PIXEL_BITS-1:0] pixel;
    logic                           row_end;

    modport source (output valid, output pixel, output row_end, input ready);
    modport sink   (input valid, input pixel, input row_end, output ready);
endinterface

// File: rtl/gme_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with result value and row marks.
// Depends on gme_pkg.
interface gme_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [gme_pkg::RESULT_W-1:0] result;
    logic                                result_row_end;
    logic                                run_last;

    modport source (output valid, output result, output result_row_end, output run_last,
                    input ready);
    modport sink   (input valid, input result, input result_row_end, input run_last,
                    output ready);
endinterface

// File: rtl/gme_queue.sv
`timescale 1ns / 1ps
// Short register queue of pending windows between front and back parts.
// Depends on gme_pkg.
module gme_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  gme_pkg::q_ctrl_t  ctrl,
    input  gme_pkg::job_t     wr_job,
    output gme_pkg::q_stat_t  stat,
    output gme_pkg::job_t     rd_job
);
    import gme_pkg::*;

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.valid = (count_reg != '0);
    assign rd_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!ctrl.push && ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && stat.full && !ctrl.pop))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> stat.valid)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

// File: rtl/gme_front.sv
`timescale 1ns / 1ps
// Front part: accepts pixels, tracks the left/center window of the row and
// queues one window per pixel that causes results. Depends on gme_pkg.
module gme_front (
    input  logic             clk,
    input  logic             rst_n,
    gme_pix_if.sink          pixels,
    input  gme_pkg::q_stat_t q_stat,
    output logic             push,
    output gme_pkg::job_t    job
);
    import gme_pkg::*;

    logic [PIXEL_BITS-1:0] left_reg, left_next;
    logic [PIXEL_BITS-1:0] center_reg, center_next;
    logic                  have_center_reg, have_center_next;
    logic                  have_left_reg, have_left_next;
    logic                  accept;

    assign pixels.ready = !q_stat.full;
    assign accept       = pixels.valid && pixels.ready;

    // A pixel that neither closes a center nor ends the row gives nothing
    assign push = accept && (have_center_reg || pixels.row_end);

    assign job.left        = have_left_reg ? left_reg : '0;
    assign job.center      = center_reg;
    assign job.right       = pixels.pixel;
    assign job.emit_center = have_center_reg;
    assign job.last        = pixels.row_end;

    always_comb
    begin
        left_next        = left_reg;
        center_next      = center_reg;
        have_center_next = have_center_reg;
        have_left_next   = have_left_reg;
        if (accept)
        begin
            left_next        = have_center_reg ? center_reg : '0;
            have_left_next   = have_center_reg && !pixels.row_end;
            center_next      = pixels.pixel;
            have_center_next = !pixels.row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg        <= '0;
            center_reg      <= '0;
            have_center_reg <= 1'b0;
            have_left_reg   <= 1'b0;
        end
        else
        begin
            left_reg        <= left_next;
            center_reg      <= center_next;
            have_center_reg <= have_center_next;
            have_left_reg   <= have_left_next;
        end
    end

    a_left_needs_center: assert property (@(posedge clk) disable iff (!rst_n)
        have_left_reg |-> have_center_reg)
        else $error("left neighbour held without a center");
    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pixels.row_end) |=> (!have_center_reg && !have_left_reg))
        else $error("row state not cleared after row end");

endmodule

// File: rtl/gme_back.sv
`timescale 1ns / 1ps
// Back part: takes queued windows, computes min of differences or max of
// sums, and holds each result in an output register. Depends on gme_pkg.
module gme_back (
    input  logic             clk,
    input  logic             rst_n,
    input  gme_pkg::cfg_t    cfg,
    input  gme_pkg::q_stat_t q_stat,
    input  gme_pkg::job_t    head,
    output logic             pop,
    gme_res_if.source        results
);
    import gme_pkg::*;

    logic                        phase_reg, phase_next;
    logic                        valid_reg, valid_next;
    logic signed [RESULT_W-1:0]  result_reg;
    logic                        row_end_reg;
    logic                        run_last_reg;

    logic                        advance;
    logic                        first;
    logic [PIXEL_BITS-1:0]       pl, pc, pr;
    logic signed [SUM_W-1:0]     el, ec, er, ol, oc, orr;
    logic signed [SUM_W-1:0]     ta, tb, td, best;

    assign advance = q_stat.valid && (!valid_reg || results.ready);
    // Center result first, then the row-end flush from the same window
    assign first   = head.emit_center && !phase_reg;
    assign pop     = advance && !(first && head.last);

    always_comb
    begin
        if (first)
        begin
            pl = head.left;
            pc = head.center;
            pr = head.right;
        end
        else
        begin
            pl = head.emit_center ? head.center : '0;
            pc = head.right;
            pr = '0;
        end
        el  = $signed({{(SUM_W-PIXEL_BITS){1'b0}}, pl});
        ec  = $signed({{(SUM_W-PIXEL_BITS){1'b0}}, pc});
        er  = $signed({{(SUM_W-PIXEL_BITS){1'b0}}, pr});
        ol  = $signed({{(SUM_W-OFFSET_W){1'b0}}, cfg.offset_left});
        oc  = $signed({{(SUM_W-OFFSET_W){1'b0}}, cfg.offset_center});
        orr = $signed({{(SUM_W-OFFSET_W){1'b0}}, cfg.offset_right});
        if (cfg.mode_dilate)
        begin
            ta = el + ol;
            tb = ec + oc;
            td = er + orr;
            best = ta;
            if (tb > best)
            begin
                best = tb;
            end
            if (td > best)
            begin
                best = td;
            end
        end
        else
        begin
            ta = el - ol;
            tb = ec - oc;
            td = er - orr;
            best = ta;
            if (tb < best)
            begin
                best = tb;
            end
            if (td < best)
            begin
                best = td;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (results.ready)
        begin
            valid_next = 1'b0;
        end
        if (advance)
        begin
            valid_next = 1'b1;
            phase_next = first && head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg   <= $signed(best[RESULT_W-1:0]);
            row_end_reg  <= !first;
            run_last_reg <= !(first && head.last);
        end
    end

    assign results.valid          = valid_reg;
    assign results.result         = result_reg;
    assign results.result_row_end = row_end_reg;
    assign results.run_last       = run_last_reg;

    a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (q_stat.valid && head.last && head.emit_center))
        else $error("flush phase without a row-end window at the head");
    a_row_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && row_end_reg) |-> run_last_reg)
        else $error("row-end result not marked as last of its item");

endmodule

// File: rtl/gray_morph_erode_dilate_1x3_top.sv
`timescale 1ns / 1ps
// 1x3 horizontal grayscale erosion/dilation over a pixel stream.
// Depends on gme_pkg, gme_pix_if, gme_res_if, gme_front, gme_queue, gme_back.
//
// Usage:
//   pixels  : one pixel per transfer, left to right, row_end on the last one.
//   results : one eroded/dilated value per center pixel, result_row_end on the
//             row's last value, run_last on the final value caused by a pixel.
//   cfg_*   : write mode_dilate and the three offsets while the block is idle.
// A center's value appears once its right neighbour is transferred; its window
// passes through the window queue and then the result register before the
// value is valid on the result port. A row-end pixel also flushes itself, so
// it produces up to two values, one per cycle while the receiver is ready.
// Throughput is one pixel per cycle while the queue is not full; the result
// output register issues one value per cycle while the receiver is ready, and
// the four-entry window queue between the front and back parts absorbs flushes.
// Reset clears the row window, the queue, the output valid and all
// configuration registers (erosion, offsets zero).
// When the receiver stalls, the queue fills; pixels keeps ready high until the
// queue is full, then holds it low until the back part drains an entry.
module gray_morph_erode_dilate_1x3_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gme_pkg::CFG_DATA_W-1:0] cfg_data,
    gme_pix_if.sink                        pixels,
    gme_res_if.source                      results
);
    import gme_pkg::*;

    cfg_t    cfg_reg;
    q_ctrl_t q_ctrl;
    q_stat_t q_stat;
    job_t    wr_job;
    job_t    rd_job;
    logic    push;
    logic    pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE_DILATE:   cfg_reg.mode_dilate   <= cfg_data[0];
                CFG_OFFSET_LEFT:   cfg_reg.offset_left   <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_CENTER: cfg_reg.offset_center <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_RIGHT:  cfg_reg.offset_right  <= cfg_data[OFFSET_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    gme_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .q_stat (q_stat),
        .push   (push),
        .job    (wr_job)
    );

    gme_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .wr_job (wr_job),
        .stat   (q_stat),
        .rd_job (rd_job)
    );

    gme_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_stat  (q_stat),
        .head    (rd_job),
        .pop     (pop),
        .results (results)
    );

endmodule
